[hw/rtl/c2svm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2svm_pkg: shared types and constants of the cube-to-sphere vertex morph
// Widths, the datapath command and status types, the cosine weight table
// builder and the coordinate saturation helper.
// ---------------------------------------------------------------------------
package c2svm_pkg;

    localparam int COS_N      = 256;
    localparam int IDX_W      = $clog2(COS_N + 1);
    localparam int COORD_W    = 16;
    localparam int TIME_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int ABS_W      = COORD_W + 1;
    localparam int SQ_W       = 32;
    localparam int ROOT_IN_W  = SQ_W + 16;
    localparam int LEN_W      = ROOT_IN_W / 2;
    localparam int MAG_W      = 32;
    localparam int NUM_W      = MAG_W + 8;
    localparam int QUO_W      = 17;
    localparam int PROD_W     = 34;
    localparam int ACC_W      = 36;
    localparam int SHIFTED_W  = ACC_W - 16;

    localparam logic [TIME_W-1:0]   DURATION_RESET = 16'd1000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 17'd65536;

    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    typedef logic [WEIGHT_W-1:0] cos_table_t [0:COS_N];

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK_STEP,
        OP_TICK_DIV,
        OP_TICK_IDX,
        OP_TICK_WEIGHT,
        OP_SQ_ACC,
        OP_SQRT_START,
        OP_MAG,
        OP_VDIV,
        OP_S_LOAD,
        OP_BL_MUL,
        OP_BL_ADD,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        logic       in_ready;
        dp_op_t     op;
        logic [1:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic dur_zero;
        logic len_zero;
        logic div_busy;
        logic div_done;
        logic sqrt_busy;
        logic sqrt_done;
        logic out_free;
    } dp_sts_t;

    // Weight for an angle index in the first half of the table, from an
    // eleven-term Taylor series of the cosine in Q2.30.
    function automatic logic [WEIGHT_W-1:0] half_weight(input int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int unsigned     k;
        x    = (PI_Q30 * 64'(i) + 64'(COS_N / 2)) / COS_N;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (k = 1; k <= 10; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return WEIGHT_W'((64'(sum) + ONE_Q30 + 64'd16384) >> 15);
    endfunction

    function automatic cos_table_t build_cos_table();
        cos_table_t  t;
        int unsigned i;
        for (i = 0; i <= COS_N; i++)
        begin
            if (2 * i <= COS_N)
                t[i] = half_weight(i);
            else
                t[i] = WEIGHT_ONE - half_weight(COS_N - i);
        end
        return t;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SHIFTED_W-1:0] v);
        if (v > SHIFTED_W'(32767))
            return 16'sh7FFF;
        else if (v < -SHIFTED_W'(32768))
            return 16'sh8000;
        else
            return v[COORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/c2svm_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2svm_if: channel interfaces of the vertex morph
// Input item channel, result channel and duration write channel.
// ---------------------------------------------------------------------------
interface c2svm_in_if;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [15:0]         elapsed_ms;
    logic signed [15:0]  coord_x;
    logic signed [15:0]  coord_y;
    logic signed [15:0]  coord_z;
    logic                last_vertex;

    modport source (output valid, operation, elapsed_ms, coord_x, coord_y, coord_z,
                    last_vertex, input ready);
    modport sink   (input valid, operation, elapsed_ms, coord_x, coord_y, coord_z,
                    last_vertex, output ready);
endinterface

interface c2svm_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  out_x;
    logic signed [15:0]  out_y;
    logic signed [15:0]  out_z;
    logic                out_last;

    modport source (output valid, out_x, out_y, out_z, out_last, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_last, output ready);
endinterface

interface c2svm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] duration_ms;

    modport source (output valid, duration_ms, input ready);
    modport sink   (input valid, duration_ms, output ready);
endinterface
`default_nettype wire

[hw/rtl/cube_to_sphere_vertex_morph.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cube_to_sphere_vertex_morph: cosine-eased cube-to-sphere vertex blend
// Top level: joins the sequencer and the datapath to the three channels.
// ---------------------------------------------------------------------------
// The req channel carries items. A tick (operation low) moves the phase by
// elapsed_ms, bouncing between zero and the configured duration, and sets
// the blend weight from the cosine table; it makes no result. A vertex
// (operation high) is projected onto the sphere through its largest
// absolute coordinate and blended with itself; one transfer on rsp follows.
// The cfg channel writes the sweep duration and is always ready; write it
// only while no item is in flight.
// Items are handled one at a time. A tick runs a division on the shared
// divider unless the duration is zero. A vertex takes a square root, then
// per coordinate a multiply and a division on the same shared divider,
// then the blend.
// The finished result waits in an output register, so a stalled receiver
// only holds the block once a second vertex is finished; ticks and the
// next vertex's work proceed meanwhile.
// Reset restores a 1000 ms duration, phase zero sweeping upward and the
// full weight, so vertices before the first tick give the sphere point.
// ---------------------------------------------------------------------------
module cube_to_sphere_vertex_morph (
    input  logic         clk,
    input  logic         rst_n,
    c2svm_in_if.sink     req,
    c2svm_out_if.source  rsp,
    c2svm_cfg_if.sink    cfg
);
    import c2svm_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // The sequencer issues one datapath command per cycle.
    c2svm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_operation (req.operation),
        .sts          (sts),
        .cmd          (cmd)
    );

    // The datapath owns every payload register and both iterative units.
    c2svm_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // A result is never loaded over one that has not been transferred.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT_LOAD) |-> !rsp.valid)
        else $error("result loaded over a pending result");

    // The shared divider is never restarted while it is working.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_TICK_DIV) || (cmd.op == OP_VDIV)) |-> !sts.div_busy)
        else $error("divider started while busy");

    // A new item is taken only when both iterative units are at rest.
    a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (!sts.div_busy && !sts.sqrt_busy))
        else $error("ready while an iterative unit is busy");

    // After a transfer in, the block is busy with that item.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second item accepted back to back");

endmodule
`default_nettype wire

[hw/rtl/c2svm_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2svm_div: shared restoring divider
// One quotient bit per cycle; the caller guarantees the quotient fits.
// ---------------------------------------------------------------------------
module c2svm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [c2svm_pkg::NUM_W-1:0]  num,
    input  logic [c2svm_pkg::LEN_W-1:0]  den,
    output logic [c2svm_pkg::QUO_W-1:0]  quo,
    output logic                         busy,
    output logic                         done
);
    import c2svm_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] den_reg;
    logic [QUO_W-1:0] low_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             fits;

    // The low register holds the unused dividend bits, then the quotient.
    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= LEN_W'(num >> QUO_W);
            low_reg <= num[QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], fits};
        end
    end

    assign quo  = low_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

[hw/rtl/c2svm_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2svm_sqrt: digit-by-digit integer square root
// One root bit per cycle, floor of the exact root.
// ---------------------------------------------------------------------------
module c2svm_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [c2svm_pkg::ROOT_IN_W-1:0] val,
    output logic [c2svm_pkg::LEN_W-1:0]     root,
    output logic                            busy,
    output logic                            done
);
    import c2svm_pkg::*;

    localparam int CNT_W = $clog2(LEN_W + 1);

    logic [ROOT_IN_W-1:0] val_reg;
    logic [LEN_W:0]       rem_reg;
    logic [LEN_W-1:0]     root_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [LEN_W+2:0]     pending;
    logic [LEN_W+2:0]     trial;
    logic [LEN_W+2:0]     diff;
    logic                 fits;

    assign pending = {rem_reg, val_reg[ROOT_IN_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign diff    = pending - trial;
    assign fits    = pending >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LEN_W);
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                root_reg <= {root_reg[LEN_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= val;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[ROOT_IN_W-3:0], 2'b00};
            rem_reg <= fits ? diff[LEN_W:0] : pending[LEN_W:0];
        end
    end

    assign root = root_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

[hw/rtl/c2svm_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2svm_dp: datapath of the vertex morph
// Phase and weight state, vertex registers, shared divider and root unit,
// blend arithmetic and the result register. Runs one command per cycle.
// ---------------------------------------------------------------------------
module c2svm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  c2svm_pkg::dp_cmd_t  cmd,
    output c2svm_pkg::dp_sts_t  sts,
    c2svm_in_if.sink            req,
    c2svm_out_if.source         rsp,
    c2svm_cfg_if.sink           cfg
);
    import c2svm_pkg::*;

    localparam cos_table_t COS_TABLE = build_cos_table();

    // Control state with reset values.
    logic [TIME_W-1:0]   duration_reg;
    logic [TIME_W-1:0]   phase_reg;
    logic                fwd_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                out_valid_reg;

    // Payload registers.
    logic [TIME_W-1:0]         elapsed_reg;
    logic signed [COORD_W-1:0] c_reg [0:2];
    logic signed [COORD_W-1:0] s_reg [0:2];
    logic signed [COORD_W-1:0] res_reg [0:2];
    logic                      last_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [ABS_W-1:0]          r_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic signed [COORD_W-1:0] out_z_reg;
    logic                      out_last_reg;

    logic                      accept;
    logic signed [COORD_W-1:0] c_sel;
    logic signed [ABS_W-1:0]   c_ext;
    logic [ABS_W-1:0]          a_sel;
    logic [2*ABS_W-1:0]        sq_term;
    logic [2*ABS_W-1:0]        mag_prod;
    logic signed [TIME_W+1:0]  phase_step;
    logic [NUM_W-1:0]          tick_num;
    logic [NUM_W-1:0]          vtx_num;
    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    logic [LEN_W-1:0]          div_den;
    logic [QUO_W-1:0]          quo;
    logic                      div_busy;
    logic                      div_done;
    logic [LEN_W-1:0]          root;
    logic                      sqrt_busy;
    logic                      sqrt_done;
    logic signed [QUO_W:0]     q_ext;
    logic signed [QUO_W:0]     s_signed;
    logic signed [WEIGHT_W:0]  w_comp;
    logic signed [WEIGHT_W:0]  w_pos;
    logic signed [COORD_W-1:0] s_eff;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [PROD_W-1:0]  prod_s;
    logic signed [ACC_W-1:0]   blend_sum;

    assign accept = req.valid && cmd.in_ready;

    assign c_sel = c_reg[cmd.sel];
    assign c_ext = {c_sel[COORD_W-1], c_sel};
    assign a_sel = c_ext[ABS_W-1] ? unsigned'(-c_ext) : unsigned'(c_ext);
    assign sq_term  = a_sel * a_sel;
    assign mag_prod = a_sel * r_reg;

    always_comb
    begin
        if (fwd_reg)
            phase_step = $signed({2'b00, phase_reg}) + $signed({2'b00, elapsed_reg});
        else
            phase_step = $signed({2'b00, phase_reg}) - $signed({2'b00, elapsed_reg});
    end

    // Rounded index: (phase * N + duration / 2) / duration.
    assign tick_num = NUM_W'({phase_reg, {IDX_W-1{1'b0}}}) + NUM_W'(duration_reg >> 1);
    assign vtx_num  = {mag_reg, 8'h00} + NUM_W'(root >> 1);

    assign div_start = (cmd.op == OP_TICK_DIV) || (cmd.op == OP_VDIV);
    assign div_num   = (cmd.op == OP_TICK_DIV) ? tick_num : vtx_num;
    assign div_den   = (cmd.op == OP_TICK_DIV) ? LEN_W'(duration_reg) : root;

    c2svm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (quo),
        .busy  (div_busy),
        .done  (div_done)
    );

    c2svm_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_SQRT_START),
        .val   ({sq_reg, 16'h0000}),
        .root  (root),
        .busy  (sqrt_busy),
        .done  (sqrt_done)
    );

    assign q_ext    = $signed({1'b0, quo});
    assign s_signed = c_sel[COORD_W-1] ? -q_ext : q_ext;

    // Blend: ((1 - w) * c + w * s + half) floor-shifted by 16.
    assign w_comp = $signed((WEIGHT_W+1)'(WEIGHT_ONE) - {1'b0, weight_reg});
    assign w_pos  = $signed({1'b0, weight_reg});
    assign s_eff  = (root == '0) ? '0 : s_reg[cmd.sel];
    assign prod_c = w_comp * c_sel;
    assign prod_s = w_pos * s_eff;
    assign blend_sum = acc_reg + ACC_W'(prod_s) + ACC_W'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg  <= DURATION_RESET;
            phase_reg     <= '0;
            fwd_reg       <= 1'b1;
            weight_reg    <= WEIGHT_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                duration_reg <= cfg.duration_ms;
            if (cmd.op == OP_TICK_STEP)
            begin
                if (phase_step >= $signed({2'b00, duration_reg}))
                begin
                    phase_reg <= duration_reg;
                    fwd_reg   <= 1'b0;
                end
                else if (phase_step <= 0)
                begin
                    phase_reg <= '0;
                    fwd_reg   <= 1'b1;
                end
                else
                    phase_reg <= phase_step[TIME_W-1:0];
            end
            if (cmd.op == OP_TICK_WEIGHT)
                weight_reg <= COS_TABLE[idx_reg];
            if (cmd.op == OP_OUT_LOAD)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elapsed_reg <= req.elapsed_ms;
            c_reg[0]    <= req.coord_x;
            c_reg[1]    <= req.coord_y;
            c_reg[2]    <= req.coord_z;
            last_reg    <= req.last_vertex;
        end
        unique case (cmd.op)
            OP_TICK_STEP:
                idx_reg <= '0;
            OP_TICK_IDX:
                idx_reg <= (quo > QUO_W'(COS_N)) ? IDX_W'(COS_N) : quo[IDX_W-1:0];
            OP_SQ_ACC:
            begin
                sq_reg <= ((cmd.sel == 2'd0) ? '0 : sq_reg) + SQ_W'(sq_term);
                if ((cmd.sel == 2'd0) || (a_sel > r_reg))
                    r_reg <= a_sel;
            end
            OP_MAG:
                mag_reg <= MAG_W'(mag_prod);
            OP_S_LOAD:
                s_reg[cmd.sel] <= sat_coord(SHIFTED_W'(s_signed));
            OP_BL_MUL:
                acc_reg <= ACC_W'(prod_c);
            OP_BL_ADD:
                res_reg[cmd.sel] <= sat_coord(blend_sum[ACC_W-1:16]);
            OP_OUT_LOAD:
            begin
                out_x_reg    <= res_reg[0];
                out_y_reg    <= res_reg[1];
                out_z_reg    <= res_reg[2];
                out_last_reg <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign cfg.ready    = 1'b1;
    assign req.ready    = cmd.in_ready;
    assign rsp.valid    = out_valid_reg;
    assign rsp.out_x    = out_x_reg;
    assign rsp.out_y    = out_y_reg;
    assign rsp.out_z    = out_z_reg;
    assign rsp.out_last = out_last_reg;

    assign sts.dur_zero  = (duration_reg == '0);
    assign sts.len_zero  = (root == '0);
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;
    assign sts.sqrt_busy = sqrt_busy;
    assign sts.sqrt_done = sqrt_done;
    assign sts.out_free  = !out_valid_reg || rsp.ready;

endmodule
`default_nettype wire

[hw/rtl/c2svm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2svm_ctrl: sequencer of the vertex morph
// Steps the datapath through a tick or a vertex, one command per cycle.
// ---------------------------------------------------------------------------
module c2svm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_operation,
    input  c2svm_pkg::dp_sts_t  sts,
    output c2svm_pkg::dp_cmd_t  cmd
);
    import c2svm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_TDIV,
        S_TWAIT,
        S_TIDX,
        S_TWGT,
        S_SQ,
        S_SQRT,
        S_SWAIT,
        S_MAG,
        S_VDIV,
        S_VWAIT,
        S_SLD,
        S_BL1,
        S_BL2,
        S_OUT
    } state_t;

    state_t  state_reg;
    dp_cmd_t cmd_reg;

    // The command register holds the operation that the datapath carries
    // out at the coming edge; each state names that operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg.in_ready <= 1'b1;
            cmd_reg.op      <= OP_NONE;
            cmd_reg.sel     <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    cmd_reg.op <= OP_NONE;
                    if (in_valid && cmd_reg.in_ready)
                    begin
                        cmd_reg.in_ready <= 1'b0;
                        cmd_reg.sel      <= 2'd0;
                        if (in_operation)
                        begin
                            cmd_reg.op <= OP_SQ_ACC;
                            state_reg  <= S_SQ;
                        end
                        else
                        begin
                            cmd_reg.op <= OP_TICK_STEP;
                            state_reg  <= S_TICK;
                        end
                    end
                end
                S_TICK:
                begin
                    if (sts.dur_zero)
                    begin
                        cmd_reg.op <= OP_TICK_WEIGHT;
                        state_reg  <= S_TWGT;
                    end
                    else
                    begin
                        cmd_reg.op <= OP_TICK_DIV;
                        state_reg  <= S_TDIV;
                    end
                end
                S_TDIV:
                begin
                    cmd_reg.op <= OP_NONE;
                    state_reg  <= S_TWAIT;
                end
                S_TWAIT:
                begin
                    if (sts.div_done)
                    begin
                        cmd_reg.op <= OP_TICK_IDX;
                        state_reg  <= S_TIDX;
                    end
                end
                S_TIDX:
                begin
                    cmd_reg.op <= OP_TICK_WEIGHT;
                    state_reg  <= S_TWGT;
                end
                S_TWGT:
                begin
                    cmd_reg.op       <= OP_NONE;
                    cmd_reg.in_ready <= 1'b1;
                    state_reg        <= S_IDLE;
                end
                S_SQ:
                begin
                    if (cmd_reg.sel == 2'd2)
                    begin
                        cmd_reg.op <= OP_SQRT_START;
                        state_reg  <= S_SQRT;
                    end
                    else
                        cmd_reg.sel <= cmd_reg.sel + 2'd1;
                end
                S_SQRT:
                begin
                    cmd_reg.op <= OP_NONE;
                    state_reg  <= S_SWAIT;
                end
                S_SWAIT:
                begin
                    if (sts.sqrt_done)
                    begin
                        cmd_reg.sel <= 2'd0;
                        if (sts.len_zero)
                        begin
                            cmd_reg.op <= OP_BL_MUL;
                            state_reg  <= S_BL1;
                        end
                        else
                        begin
                            cmd_reg.op <= OP_MAG;
                            state_reg  <= S_MAG;
                        end
                    end
                end
                S_MAG:
                begin
                    cmd_reg.op <= OP_VDIV;
                    state_reg  <= S_VDIV;
                end
                S_VDIV:
                begin
                    cmd_reg.op <= OP_NONE;
                    state_reg  <= S_VWAIT;
                end
                S_VWAIT:
                begin
                    if (sts.div_done)
                    begin
                        cmd_reg.op <= OP_S_LOAD;
                        state_reg  <= S_SLD;
                    end
                end
                S_SLD:
                begin
                    if (cmd_reg.sel == 2'd2)
                    begin
                        cmd_reg.sel <= 2'd0;
                        cmd_reg.op  <= OP_BL_MUL;
                        state_reg   <= S_BL1;
                    end
                    else
                    begin
                        cmd_reg.sel <= cmd_reg.sel + 2'd1;
                        cmd_reg.op  <= OP_MAG;
                        state_reg   <= S_MAG;
                    end
                end
                S_BL1:
                begin
                    cmd_reg.op <= OP_BL_ADD;
                    state_reg  <= S_BL2;
                end
                S_BL2:
                begin
                    if (cmd_reg.sel == 2'd2)
                    begin
                        cmd_reg.op <= OP_NONE;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        cmd_reg.sel <= cmd_reg.sel + 2'd1;
                        cmd_reg.op  <= OP_BL_MUL;
                        state_reg   <= S_BL1;
                    end
                end
                S_OUT:
                begin
                    // Load the result only once the output register is free.
                    if (cmd_reg.op == OP_OUT_LOAD)
                    begin
                        cmd_reg.op       <= OP_NONE;
                        cmd_reg.in_ready <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else if (sts.out_free)
                        cmd_reg.op <= OP_OUT_LOAD;
                end
                default:
                begin
                    cmd_reg.op <= OP_NONE;
                    state_reg  <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd = cmd_reg;

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the cube-to-sphere vertex morph
// Sends ticks and vertices, predicts each morphed vertex with its own model
// of phase, weight and sphere projection, and compares every result transfer.
// ---------------------------------------------------------------------------
module testbench;
    import c2svm_pkg::*;

    // One pending input item.
    typedef struct {
        logic               operation;
        logic [15:0]        elapsed_ms;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic               last_vertex;
    } morph_item_t;

    // One morphed vertex as the block should return it.
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
    } morph_vertex_t;

    localparam logic   TICK_OP      = 1'b0;
    localparam logic   VERTEX_OP    = 1'b1;
    localparam longint LIMIT_CYCLES = 1500000;
    localparam int     HOLD_CYCLES  = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    c2svm_in_if  req ();
    c2svm_out_if rsp ();
    c2svm_cfg_if cfg ();

    cube_to_sphere_vertex_morph u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #2 clk = ~clk;

    // Predictor state: our own copy of the sweep and the weight table.
    logic [16:0]      weight_lut [0:COS_N];
    int unsigned      sweep_len;
    int unsigned      sweep_phase;
    bit               sweep_up;
    longint           cur_weight;

    morph_item_t      pending_items [$];
    morph_vertex_t    expected_vertices [$];

    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_receiver;
    bit  start_hold = 1'b0;
    int  hold_left;
    bit  hold_sender = 1'b0;
    longint cycle_count = 0;

    // Taylor-series cosine weight for the first half of the table.
    function automatic longint lut_half(input longint i);
        longint unsigned xa, xsq, term;
        longint sum;
        xa   = (64'd3373259426 * i + COS_N / 2) / COS_N;
        xsq  = (xa * xa) >> 30;
        term = 64'd1073741824;
        sum  = 64'd1073741824;
        for (int k = 1; k <= 10; k++)
        begin
            term = ((term * xsq) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
                sum -= term;
            else
                sum += term;
        end
        if (sum < 0)
            sum = 0;
        return (sum + 64'd1073741824 + 16384) >>> 15;
    endfunction

    function automatic longint isqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Advances the ping-pong phase and picks the eased weight.
    task automatic advance_sweep(input logic [15:0] elapsed);
        longint p, idx;
        p = sweep_up ? longint'(sweep_phase) + longint'(elapsed)
                     : longint'(sweep_phase) - longint'(elapsed);
        if (p >= longint'(sweep_len))
        begin
            sweep_phase = sweep_len;
            sweep_up    = 1'b0;
        end
        else if (p <= 0)
        begin
            sweep_phase = 0;
            sweep_up    = 1'b1;
        end
        else
            sweep_phase = 32'(p);
        if (sweep_len == 0)
            idx = 0;
        else
        begin
            idx = (longint'(sweep_phase) * COS_N + sweep_len / 2) / sweep_len;
            if (idx > COS_N)
                idx = COS_N;
        end
        cur_weight = weight_lut[idx];
    endtask

    // Projects the vertex onto its sphere and blends with the current weight.
    function automatic morph_vertex_t morph_vertex(input morph_item_t it);
        morph_vertex_t mv;
        longint c [3];
        longint o [3];
        longint radius, a, len, q, s, blend;
        longint unsigned sq, mag;
        c[0] = it.coord_x;
        c[1] = it.coord_y;
        c[2] = it.coord_z;
        radius = 0;
        sq     = 0;
        for (int j = 0; j < 3; j++)
        begin
            a = c[j] < 0 ? -c[j] : c[j];
            if (a > radius)
                radius = a;
            sq += a * a;
        end
        len = isqrt(sq << 16);
        for (int j = 0; j < 3; j++)
        begin
            if (len == 0)
                s = 0;
            else
            begin
                mag = ((c[j] < 0 ? -c[j] : c[j]) * radius) << 8;
                q   = (mag + len / 2) / len;
                s   = clamp16(c[j] < 0 ? -q : q);
            end
            blend = (65536 - cur_weight) * c[j] + cur_weight * s + 32768;
            o[j]  = clamp16(blend >>> 16);
        end
        mv.x    = 16'(o[0]);
        mv.y    = 16'(o[1]);
        mv.z    = 16'(o[2]);
        mv.last = it.last_vertex;
        return mv;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Driver: presents the head of the queue and predicts on each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.operation   <= 1'b0;
            req.elapsed_ms  <= '0;
            req.coord_x     <= '0;
            req.coord_y     <= '0;
            req.coord_z     <= '0;
            req.last_vertex <= 1'b0;
        end
        else
        begin
            morph_item_t head;
            if (req.valid && req.ready)
            begin
                head = pending_items.pop_front();
                if (head.operation == VERTEX_OP)
                    expected_vertices.push_back(morph_vertex(head));
                else
                    advance_sweep(head.elapsed_ms);
            end
            if (req.valid && !req.ready)
            begin
                // The offered item stays in place until it is transferred.
            end
            else if (pending_items.size() > 0 && !hold_sender
                && $urandom_range(99) >= send_idle_pct)
            begin
                head = pending_items[0];
                req.valid       <= 1'b1;
                req.operation   <= head.operation;
                req.elapsed_ms  <= head.elapsed_ms;
                req.coord_x     <= head.coord_x;
                req.coord_y     <= head.coord_y;
                req.coord_z     <= head.coord_z;
                req.last_vertex <= head.last_vertex;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Monitor: checks every result transfer against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            morph_vertex_t want;
            if (rsp.valid && rsp.ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    $display("unexpected result transfer");
                    error_count++;
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (rsp.out_x !== want.x)
                        report_mismatch("out_x", rsp.out_x, want.x);
                    if (rsp.out_y !== want.y)
                        report_mismatch("out_y", rsp.out_y, want.y);
                    if (rsp.out_z !== want.z)
                        report_mismatch("out_z", rsp.out_z, want.z);
                    if (rsp.out_last !== want.last)
                        report_mismatch("out_last", rsp.out_last, want.last);
                end
            end
            rsp.ready <= !hold_receiver && $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Long receiver hold: once requested, keeps ready low until the hold counter runs out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_receiver <= 1'b0;
            hold_left     <= 0;
        end
        else if (hold_receiver)
        begin
            hold_left <= hold_left - 1;
            if (hold_left <= 1)
                hold_receiver <= 1'b0;
        end
        else if (start_hold)
        begin
            hold_receiver <= 1'b1;
            hold_left     <= HOLD_CYCLES;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic morph_item_t make_tick(input logic [15:0] e);
        morph_item_t it;
        it = '{operation: TICK_OP, elapsed_ms: e, coord_x: 16'($urandom),
               coord_y: 16'($urandom), coord_z: 16'($urandom),
               last_vertex: 1'($urandom_range(1))};
        return it;
    endfunction

    function automatic morph_item_t make_vertex(input logic [15:0] x, input logic [15:0] y,
                                                input logic [15:0] z, input logic lst);
        morph_item_t it;
        it = '{operation: VERTEX_OP, elapsed_ms: 16'($urandom), coord_x: x, coord_y: y,
               coord_z: z, last_vertex: lst};
        return it;
    endfunction

    // Random coordinate: mostly cube-like values, sometimes the extremes.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(32)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_vertices.size() > 0)
            @(posedge clk);
        // A trailing tick may still be in progress; give it time to finish.
        repeat (60) @(posedge clk);
    endtask

    // Writes the duration register while the block has nothing in flight.
    task automatic write_duration(input logic [15:0] d);
        cfg.valid       <= 1'b1;
        cfg.duration_ms <= d;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        sweep_len = d;
    endtask

    task automatic queue_random(input int n);
        logic frame;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(3))
                    0: pending_items.push_back(make_tick(16'($urandom)));
                    1: pending_items.push_back(make_tick(16'd0));
                    default: pending_items.push_back(make_tick(16'($urandom_range(300))));
                endcase
            end
            else
            begin
                frame = ($urandom_range(8) == 0);
                pending_items.push_back(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                                                    frame));
            end
        end
    endtask

    initial
    begin
        logic [15:0] settings [5];
        // Fill the weight table and reset the predicted state.
        for (int i = 0; i <= COS_N; i++)
            weight_lut[i] = (2 * i <= COS_N) ? 17'(lut_half(i))
                                             : 17'(65536 - lut_half(COS_N - i));
        sweep_len   = 1000;
        sweep_phase = 0;
        sweep_up    = 1'b1;
        cur_weight  = 65536;

        cfg.valid       = 1'b0;
        cfg.duration_ms = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a vertex before any tick gives the pure sphere point,
        // the zero vertex maps to the origin, and the coordinate extremes.
        pending_items.push_back(make_vertex(16'h4000, 16'h2000, 16'hE000, 1'b0));
        pending_items.push_back(make_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1));
        pending_items.push_back(make_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0));
        pending_items.push_back(make_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        pending_items.push_back(make_vertex(16'h8000, 16'h7FFF, 16'h0001, 1'b0));
        pending_items.push_back(make_tick(16'd250));
        pending_items.push_back(make_vertex(16'h4000, 16'h4000, 16'h4000, 1'b0));
        pending_items.push_back(make_tick(16'd500));
        pending_items.push_back(make_vertex(16'hC000, 16'h4000, 16'h1234, 1'b1));
        pending_items.push_back(make_tick(16'hFFFF));  // clamp at the top end
        pending_items.push_back(make_vertex(16'h4000, 16'hC000, 16'h0100, 1'b0));
        pending_items.push_back(make_tick(16'hFFFF));  // clamp at the bottom end
        pending_items.push_back(make_vertex(16'h0001, 16'hFFFF, 16'h0000, 1'b1));
        pending_items.push_back(make_tick(16'd0));
        pending_items.push_back(make_tick(16'd700));
        pending_items.push_back(make_vertex(16'h2AAA, 16'hD555, 16'h7000, 1'b0));
        wait_drained();

        // Lowering the duration below the phase clamps on the next tick.
        write_duration(16'd100);
        pending_items.push_back(make_tick(16'd0));
        pending_items.push_back(make_vertex(16'h3000, 16'h1000, 16'hF000, 1'b1));
        wait_drained();

        // Zero duration holds the phase at zero with full weight.
        write_duration(16'd0);
        pending_items.push_back(make_tick(16'd37));
        pending_items.push_back(make_vertex(16'h3000, 16'h1000, 16'hF000, 1'b0));
        wait_drained();

        // Back pressure: the receiver holds off while the sender keeps going.
        write_duration(16'd1);
        queue_random(30);
        start_hold = 1'b1;
        wait (hold_receiver);
        start_hold = 1'b0;
        wait (!hold_receiver);
        wait_drained();

        // Random phases across durations and idle patterns.
        settings = '{16'd1, 16'd65535, 16'd1000, 16'd300, 16'd17};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_duration(ph == 4 ? 16'($urandom_range(65535)) : settings[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            queue_random(120);
            // The sender pauses until every result of the first half is back.
            while (pending_items.size() > 0)
                @(posedge clk);
            hold_sender = 1'b1;
            while (expected_vertices.size() > 0)
                @(posedge clk);
            hold_sender = 1'b0;
            queue_random(120);
            wait_drained();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
